FILE: hw/rtl/adcr_pkg.sv
package adcr_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int RESULT_BITS  = 10;
    localparam int NREGS        = 23;
    localparam int LEVEL_W      = 18;
    localparam int COUNT_W      = 12;
    localparam int CH_W         = 4;
    localparam int OFS_W        = 5;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_LEVEL = 2'd3
    } op_t;

    localparam logic [OFS_W-1:0] OFS_CTRLC    = 5'h02;
    localparam logic [OFS_W-1:0] OFS_MUXPOS   = 5'h06;
    localparam logic [OFS_W-1:0] OFS_HOLE_A   = 5'h07;
    localparam logic [OFS_W-1:0] OFS_COMMAND  = 5'h08;
    localparam logic [OFS_W-1:0] OFS_INTCTRL  = 5'h0A;
    localparam logic [OFS_W-1:0] OFS_INTFLAGS = 5'h0B;
    localparam logic [OFS_W-1:0] OFS_TEMP     = 5'h0D;
    localparam logic [OFS_W-1:0] OFS_HOLE_B   = 5'h0E;
    localparam logic [OFS_W-1:0] OFS_HOLE_C   = 5'h0F;
    localparam logic [OFS_W-1:0] OFS_RESL     = 5'h10;
    localparam logic [OFS_W-1:0] OFS_RESH     = 5'h11;
    localparam logic [OFS_W-1:0] OFS_WINLTL   = 5'h12;
    localparam logic [OFS_W-1:0] OFS_WINLTH   = 5'h13;
    localparam logic [OFS_W-1:0] OFS_WINHTL   = 5'h14;
    localparam logic [OFS_W-1:0] OFS_WINHTH   = 5'h15;

    localparam logic [4:0] MUX_FULL = 5'h1C;
    localparam logic [4:0] MUX_HALF = 5'h1E;

    localparam logic signed [LEVEL_W-1:0] FULL_SCALE = 18'sd65536;
    localparam logic signed [LEVEL_W-1:0] HALF_SCALE = 18'sd32768;

    typedef struct packed {
        op_t                       operation;
        logic [OFS_W-1:0]          reg_offset;
        logic [7:0]                write_data;
        logic [CH_W-1:0]           channel;
        logic signed [LEVEL_W-1:0] level;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_offset;
        logic       irq_withdraw;
        logic       conversion_done;
    } result_t;

    // Countdown for prescale P = 2 << code: P/2 + 2 + 13*P = (27 << code) + 2.
    function automatic logic [COUNT_W-1:0] countdown_load(input logic [2:0] code);
        return (COUNT_W'(27) << code) + COUNT_W'(2);
    endfunction

    function automatic logic [RESULT_BITS-1:0] quantize(
        input logic signed [LEVEL_W-1:0] lv
    );
        logic [RESULT_BITS-1:0] q;
        if (lv >= FULL_SCALE) begin
            q = '1;
        end
        else if (lv <= 18'sd0) begin
            q = '0;
        end
        else begin
            q = lv[15 -: RESULT_BITS];
        end
        return q;
    endfunction

endpackage

FILE: hw/rtl/adcr_in_stage.sv
module adcr_in_stage
    import adcr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_take,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/adcr_core.sv
module adcr_core
    import adcr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    logic [7:0]                bytes_reg  [NREGS];
    logic [7:0]                bytes_next [NREGS];
    logic signed [LEVEL_W-1:0] levels_reg  [NUM_CHANNELS];
    logic signed [LEVEL_W-1:0] levels_next [NUM_CHANNELS];
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [COUNT_W-1:0]        count_dec;
    logic                      busy_reg;
    logic                      busy_next;

    logic                      mapped;
    logic [4:0]                mux_code;
    logic signed [LEVEL_W-1:0] sel_level;
    logic [RESULT_BITS-1:0]    conv;
    logic [15:0]               conv_wide;
    logic [OFS_W-1:0]          ofs;

    assign ofs    = item.reg_offset;
    assign mapped = (5'(NREGS) > ofs) && (ofs != OFS_HOLE_A) &&
                    (ofs != OFS_HOLE_B) && (ofs != OFS_HOLE_C);

    assign mux_code = bytes_reg[OFS_MUXPOS][4:0];

    always_comb
    begin
        if (mux_code < 5'(NUM_CHANNELS))
        begin
            sel_level = levels_reg[mux_code[CH_W-1:0]];
        end
        else if (mux_code == MUX_FULL)
        begin
            sel_level = FULL_SCALE;
        end
        else if (mux_code == MUX_HALF)
        begin
            sel_level = HALF_SCALE;
        end
        else
        begin
            sel_level = '0;
        end
    end

    assign conv      = quantize(sel_level);
    assign conv_wide = 16'(conv);
    assign count_dec = (count_reg != '0) ? count_reg - COUNT_W'(1) : count_reg;

    always_comb
    begin
        bytes_next  = bytes_reg;
        levels_next = levels_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        result      = '0;

        if (fire)
        begin
            unique case (item.operation)
                OP_READ:
                begin
                    if (!mapped)
                    begin
                        result.bad_offset = 1'b1;
                    end
                    else
                    begin
                        priority if (ofs == OFS_RESL)
                        begin
                            bytes_next[OFS_INTFLAGS][0] = 1'b0;
                            result.irq_withdraw         = 1'b1;
                            bytes_next[OFS_TEMP]        = bytes_reg[OFS_RESH];
                            result.read_data            = bytes_reg[OFS_RESL];
                        end
                        else if (ofs == OFS_WINLTL)
                        begin
                            bytes_next[OFS_TEMP] = bytes_reg[OFS_WINLTH];
                            result.read_data     = bytes_reg[OFS_WINLTL];
                        end
                        else if (ofs == OFS_WINHTL)
                        begin
                            bytes_next[OFS_TEMP] = bytes_reg[OFS_WINHTH];
                            result.read_data     = bytes_reg[OFS_WINHTL];
                        end
                        else if (ofs == OFS_RESH || ofs == OFS_WINLTH ||
                                 ofs == OFS_WINHTH)
                        begin
                            result.read_data = bytes_reg[OFS_TEMP];
                        end
                        else
                        begin
                            result.read_data = bytes_reg[ofs];
                        end
                    end
                end
                OP_WRITE:
                begin
                    if (!mapped)
                    begin
                        result.bad_offset = 1'b1;
                    end
                    else
                    begin
                        // A start while busy reloads the countdown and abandons the old one.
                        if (ofs == OFS_COMMAND && item.write_data[0])
                        begin
                            count_next = countdown_load(bytes_reg[OFS_CTRLC][2:0]);
                            busy_next  = 1'b1;
                        end
                        if (ofs == OFS_INTCTRL && !item.write_data[0])
                        begin
                            result.irq_withdraw = 1'b1;
                        end
                        bytes_next[ofs] = item.write_data;
                    end
                end
                OP_TICK:
                begin
                    if (busy_reg)
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            busy_next                   = 1'b0;
                            bytes_next[OFS_RESL]        = conv_wide[7:0];
                            bytes_next[OFS_RESH]        = conv_wide[15:8];
                            bytes_next[OFS_INTFLAGS][0] = 1'b1;
                            bytes_next[OFS_COMMAND][0]  = 1'b0;
                            result.conversion_done      = 1'b1;
                        end
                    end
                end
                OP_LEVEL:
                begin
                    if ({1'b0, item.channel} < 5'(NUM_CHANNELS))
                    begin
                        levels_next[item.channel] = item.level;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                bytes_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                levels_reg[i] <= '0;
            end
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            bytes_reg  <= bytes_next;
            levels_reg <= levels_next;
            count_reg  <= count_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

FILE: hw/rtl/adc_registers_with_timed_conversion.sv
// Register interface of a 10-bit converter. Each transaction is a byte read, a byte write,
// one peripheral clock tick or a new level for an analog channel, and each gives exactly one
// result transaction. The block sustains one transaction per cycle while the output is not
// stalled. An input transaction is taken into the input register; once the result register
// is free, the execute logic updates the register bytes, channel levels and conversion
// countdown and loads the result register, which offers the result. A stalled output holds the
// result register, and the input is held off once the input register is also full. A start
// written to COMMAND converts after (27 << CTRLC[2:0]) + 2 tick transactions.
module adc_registers_with_timed_conversion
    import adcr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic [OFS_W-1:0]          reg_offset,
    input  logic [7:0]                write_data,
    input  logic [CH_W-1:0]           channel,
    input  logic signed [LEVEL_W-1:0] level,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                read_data,
    output logic                      bad_offset,
    output logic                      irq_withdraw,
    output logic                      conversion_done
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_free;

    assign in_item.operation  = op_t'(operation);
    assign in_item.reg_offset = reg_offset;
    assign in_item.write_data = write_data;
    assign in_item.channel    = channel;
    assign in_item.level      = level;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = item_valid && out_free;

    adcr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    adcr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = result_reg.read_data;
    assign bad_offset      = result_reg.bad_offset;
    assign irq_withdraw    = result_reg.irq_withdraw;
    assign conversion_done = result_reg.conversion_done;

endmodule

FILE: test/adc_registers_with_timed_conversion_tb.sv
module adc_registers_with_timed_conversion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adcr_pkg::*;

    localparam logic [OFS_W-1:0] OFS_CTRLA      = 5'h00;
    localparam logic [OFS_W-1:0] OFS_FIRST_FREE = 5'h17;
    localparam logic [OFS_W-1:0] OFS_LAST       = 5'h1F;
    localparam logic [4:0]       MUX_NONE       = 5'h1F;
    localparam logic [7:0]       CMD_START      = 8'h01;
    localparam logic [7:0]       IRQ_ENABLE     = 8'h01;
    localparam int               RANDOM_ITEMS   = 1100;

    typedef struct {
        item_t   it;
        int      reps;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                operation;
    logic [OFS_W-1:0]          reg_offset;
    logic [7:0]                write_data;
    logic [CH_W-1:0]           channel;
    logic signed [LEVEL_W-1:0] level;
    logic                      out_valid;
    logic                      out_ready;
    logic [7:0]                read_data;
    logic                      bad_offset;
    logic                      irq_withdraw;
    logic                      conversion_done;

    // Shadow copy of the converter state, advanced once per accepted transaction.
    logic [7:0]                reg_bytes [NREGS];
    logic signed [LEVEL_W-1:0] pin_level [16];
    logic [COUNT_W-1:0]        conv_count;
    logic                      conv_busy;

    result_t pending_results[$];
    int      n_fail = 0;
    int      n_checked = 0;
    int      n_conversions = 0;
    int      n_unmapped = 0;
    int      n_sent = 0;
    bit      gapless = 1'b0;

    adc_registers_with_timed_conversion uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .reg_offset      (reg_offset),
        .write_data      (write_data),
        .channel         (channel),
        .level           (level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .bad_offset      (bad_offset),
        .irq_withdraw    (irq_withdraw),
        .conversion_done (conversion_done)
    );

    always #5 clk = ~clk;

    function automatic bit is_mapped(input logic [OFS_W-1:0] ofs);
        return ofs < NREGS && ofs != OFS_HOLE_A && ofs != OFS_HOLE_B && ofs != OFS_HOLE_C;
    endfunction

    function automatic logic [RESULT_BITS-1:0] sample_level();
        int         lv;
        logic [4:0] code;
        code = reg_bytes[OFS_MUXPOS][4:0];
        if (code < NUM_CHANNELS)
            lv = pin_level[code[3:0]];
        else if (code == MUX_FULL)
            lv = int'(FULL_SCALE);
        else if (code == MUX_HALF)
            lv = int'(HALF_SCALE);
        else
            lv = 0;
        if (lv >= int'(FULL_SCALE))
            return '1;
        if (lv <= 0)
            return '0;
        return RESULT_BITS'(lv >> (16 - RESULT_BITS));
    endfunction

    function automatic result_t step_adc(input item_t it);
        result_t                r;
        logic [OFS_W-1:0]       ofs;
        logic [RESULT_BITS-1:0] q;
        int                     fact;
        r = '0;
        ofs = it.reg_offset;
        case (it.operation)
            OP_READ:
            begin
                if (!is_mapped(ofs))
                begin
                    r.bad_offset = 1'b1;
                end
                else if (ofs == OFS_RESL)
                begin
                    reg_bytes[OFS_INTFLAGS][0] = 1'b0;
                    r.irq_withdraw = 1'b1;
                    reg_bytes[OFS_TEMP] = reg_bytes[OFS_RESH];
                    r.read_data = reg_bytes[OFS_RESL];
                end
                else if (ofs == OFS_WINLTL || ofs == OFS_WINHTL)
                begin
                    reg_bytes[OFS_TEMP] = reg_bytes[ofs + 1];
                    r.read_data = reg_bytes[ofs];
                end
                else if (ofs == OFS_RESH || ofs == OFS_WINLTH || ofs == OFS_WINHTH)
                begin
                    r.read_data = reg_bytes[OFS_TEMP];
                end
                else
                begin
                    r.read_data = reg_bytes[ofs];
                end
            end
            OP_WRITE:
            begin
                if (!is_mapped(ofs))
                begin
                    r.bad_offset = 1'b1;
                end
                else
                begin
                    // A start reloads the countdown even when a conversion is running.
                    if (ofs == OFS_COMMAND && (it.write_data & CMD_START) != 0)
                    begin
                        fact = 2 << reg_bytes[OFS_CTRLC][2:0];
                        conv_count = COUNT_W'(fact / 2 + 2 + 13 * fact);
                        conv_busy = 1'b1;
                    end
                    if (ofs == OFS_INTCTRL && (it.write_data & IRQ_ENABLE) == 0)
                        r.irq_withdraw = 1'b1;
                    reg_bytes[ofs] = it.write_data;
                end
            end
            OP_TICK:
            begin
                if (conv_busy)
                begin
                    if (conv_count != 0)
                        conv_count = conv_count - 1'b1;
                    if (conv_count == 0)
                    begin
                        conv_busy = 1'b0;
                        q = sample_level();
                        reg_bytes[OFS_RESL] = q[7:0];
                        reg_bytes[OFS_RESH] = 8'(q >> 8);
                        reg_bytes[OFS_INTFLAGS][0] = 1'b1;
                        reg_bytes[OFS_COMMAND][0] = 1'b0;
                        r.conversion_done = 1'b1;
                    end
                end
            end
            default:
            begin
                if (it.channel < NUM_CHANNELS)
                    pin_level[it.channel] = it.level;
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (gapless)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_level();
        case ($urandom_range(0, 11))
            0: return 65536;
            1: return -65536;
            2: return 0;
            3: return 1;
            4: return -1;
            5: return 65535;
            6: return 63;
            7: return 64;
            8: return 32768;
            default: return int'($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    function automatic item_t junk_item();
        item_t it;
        it.operation  = op_t'($urandom_range(0, 3));
        it.reg_offset = OFS_W'($urandom);
        it.write_data = 8'($urandom);
        it.channel    = CH_W'($urandom);
        it.level      = LEVEL_W'(pick_level());
        return it;
    endfunction

    function automatic result_t res(input logic [7:0] rd, input bit bad, input bit wdr);
        result_t r;
        r.read_data       = rd;
        r.bad_offset      = bad;
        r.irq_withdraw    = wdr;
        r.conversion_done = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t row(input op_t op, input logic [OFS_W-1:0] ofs,
                                     input logic [7:0] wd, input logic [CH_W-1:0] ch,
                                     input int lvl, input int reps, input bit typed,
                                     input result_t want);
        dir_row_t d;
        d.it.operation  = op;
        d.it.reg_offset = ofs;
        d.it.write_data = wd;
        d.it.channel    = ch;
        d.it.level      = LEVEL_W'(lvl);
        d.reps          = reps;
        d.typed         = typed;
        d.want          = want;
        return d;
    endfunction

    task automatic send_item(input item_t it, input bit typed = 1'b0,
                             input result_t want = '0);
        int      gap;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= it.operation;
        reg_offset <= it.reg_offset;
        write_data <= it.write_data;
        channel    <= it.channel;
        level      <= it.level;
        do @(posedge clk); while (!in_ready);
        predicted = step_adc(it);
        pending_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    task automatic bus_read(input logic [OFS_W-1:0] ofs);
        item_t it;
        it = junk_item();
        it.operation  = OP_READ;
        it.reg_offset = ofs;
        send_item(it);
    endtask

    task automatic bus_write(input logic [OFS_W-1:0] ofs, input logic [7:0] wd);
        item_t it;
        it = junk_item();
        it.operation  = OP_WRITE;
        it.reg_offset = ofs;
        it.write_data = wd;
        send_item(it);
    endtask

    task automatic tick();
        item_t it;
        it = junk_item();
        it.operation = OP_TICK;
        send_item(it);
    endtask

    task automatic set_level(input logic [CH_W-1:0] ch, input int lvl);
        item_t it;
        it = junk_item();
        it.operation = OP_LEVEL;
        it.channel   = ch;
        it.level     = LEVEL_W'(lvl);
        send_item(it);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // A conversion: levels, prescale, mux, start, ticks mixed with other transactions until done, mostly a result read.
    task automatic run_conversion();
        logic [2:0]       code;
        logic [4:0]       mux;
        logic [OFS_W-1:0] ofs;
        int               r;
        repeat ($urandom_range(0, 3)) set_level(CH_W'($urandom), pick_level());
        r = $urandom_range(0, 99);
        code = (r < 70) ? 3'd0 : (r < 95) ? 3'd1 : 3'd2;
        bus_write(OFS_CTRLC, {5'($urandom), code});
        r = $urandom_range(0, 99);
        if (r < 60)
            mux = 5'($urandom_range(0, 15));
        else if (r < 70)
            mux = MUX_FULL;
        else if (r < 78)
            mux = MUX_HALF;
        else if (r < 85)
            mux = MUX_NONE;
        else
            mux = 5'($urandom_range(16, 31));
        bus_write(OFS_MUXPOS, {3'($urandom), mux});
        if (mux < NUM_CHANNELS && $urandom_range(0, 4) == 0)
            set_level(mux[3:0], pick_level());
        bus_write(OFS_COMMAND, 8'($urandom) | CMD_START);
        while (conv_busy)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                tick();
            end
            else if (r < 93)
            begin
                bus_read(OFS_W'($urandom));
            end
            else if (r < 97)
            begin
                set_level(CH_W'($urandom), pick_level());
            end
            else
            begin
                // Keep COMMAND out of the way so that the conversion is sure to finish.
                ofs = OFS_W'($urandom);
                if (ofs != OFS_COMMAND)
                    bus_write(ofs, 8'($urandom));
            end
        end
        if ($urandom_range(0, 3) == 0)
            bus_read(OFS_INTFLAGS);
        if ($urandom_range(0, 9) != 0)
        begin
            bus_read(OFS_RESL);
            bus_read(OFS_RESH);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            bus_read($urandom_range(0, 1) ? OFS_WINLTL : OFS_WINHTL);
            bus_read($urandom_range(0, 1) ? OFS_WINLTH : OFS_WINHTH);
        end
    endtask

    task automatic broken_sequence();
        bus_write(OFS_CTRLC, {5'($urandom), 3'($urandom_range(0, 1))});
        bus_write(OFS_COMMAND, CMD_START);
        repeat ($urandom_range(0, 20)) tick();
        case ($urandom_range(0, 2))
            0: bus_write(OFS_COMMAND, CMD_START);
            1: bus_write(OFS_COMMAND, 8'($urandom) & ~CMD_START);
            default: bus_read(OFS_RESH);
        endcase
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_checked++;
            if (conversion_done)
                n_conversions++;
            if (bad_offset)
                n_unmapped++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: read_data %h bad_offset %b",
                         $time, read_data, bad_offset);
                $display("%0t: unexpected result: irq_withdraw %b conversion_done %b",
                         $time, irq_withdraw, conversion_done);
                n_fail++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, read_data);
                    n_fail++;
                end
                if (bad_offset !== want.bad_offset)
                begin
                    $display("%0t: bad_offset expected %b actual %b",
                             $time, want.bad_offset, bad_offset);
                    n_fail++;
                end
                if (irq_withdraw !== want.irq_withdraw)
                begin
                    $display("%0t: irq_withdraw expected %b actual %b",
                             $time, want.irq_withdraw, irq_withdraw);
                    n_fail++;
                end
                if (conversion_done !== want.conversion_done)
                begin
                    $display("%0t: conversion_done expected %b actual %b",
                             $time, want.conversion_done, conversion_done);
                    n_fail++;
                end
            end
        end
    end

    // Receiver side: mostly short stalls, a few long ones, and long runs with none.
    initial
    begin
        int r;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge clk);
            end
            else if (r < 50)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else if (r < 93)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    initial
    begin
        dir_row_t plan[$];
        int       start_sent;
        int       scen;
        int       r;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        operation  <= OP_READ;
        reg_offset <= '0;
        write_data <= '0;
        channel    <= '0;
        level      <= '0;
        foreach (reg_bytes[i])
            reg_bytes[i] = 8'h00;
        foreach (pin_level[i])
            pin_level[i] = '0;
        conv_count = '0;
        conv_busy  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        //                    op        offset          data   ch  level   reps  typed  expected
        plan.push_back(row(OP_READ,  OFS_CTRLA,      8'h00, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_READ,  OFS_HOLE_A,     8'h00, 0,  0,      1,    1, res(8'h00, 1'b1, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_LAST,       8'hFF, 0,  0,      1,    1, res(8'h00, 1'b1, 1'b0)));
        plan.push_back(row(OP_READ,  OFS_FIRST_FREE, 8'h00, 0,  0,      1,    1, res(8'h00, 1'b1, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_HOLE_C,     8'h5A, 0,  0,      1,    1, res(8'h00, 1'b1, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_INTCTRL,    8'h00, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b1)));
        plan.push_back(row(OP_WRITE, OFS_INTCTRL,    8'h01, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_LEVEL, OFS_CTRLA,      8'h00, 0,  65536,  1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_LEVEL, OFS_CTRLA,      8'h00, 15, -65536, 1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_MUXPOS,     8'h00, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_CTRLC,      8'h00, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_COMMAND,    8'h01, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_TICK,  OFS_CTRLA,      8'h00, 0,  0,      29,   0, '0));
        plan.push_back(row(OP_READ,  OFS_RESL,       8'h00, 0,  0,      1,    1, res(8'hFF, 1'b0, 1'b1)));
        plan.push_back(row(OP_READ,  OFS_RESH,       8'h00, 0,  0,      1,    1, res(8'h03, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_WINLTH,     8'hAB, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_READ,  OFS_WINLTL,     8'h00, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_READ,  OFS_WINLTH,     8'h00, 0,  0,      1,    1, res(8'hAB, 1'b0, 1'b0)));
        // Half scale, a start, a COMMAND write with the start bit clear, then a restart mid-conversion.
        plan.push_back(row(OP_WRITE, OFS_MUXPOS,     8'hFE, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_COMMAND,    8'h01, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_COMMAND,    8'hFE, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_TICK,  OFS_CTRLA,      8'h00, 0,  0,      10,   0, '0));
        plan.push_back(row(OP_WRITE, OFS_COMMAND,    8'h01, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_TICK,  OFS_CTRLA,      8'h00, 0,  0,      29,   0, '0));
        plan.push_back(row(OP_READ,  OFS_RESL,       8'h00, 0,  0,      1,    0, '0));
        plan.push_back(row(OP_READ,  OFS_RESH,       8'h00, 0,  0,      1,    0, '0));
        // A longer prescale with the upper CTRLC bits set, on a channel held at
        // negative full scale.
        plan.push_back(row(OP_WRITE, OFS_CTRLC,      8'hFB, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_MUXPOS,     8'h0F, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_WRITE, OFS_COMMAND,    8'h01, 0,  0,      1,    1, res(8'h00, 1'b0, 1'b0)));
        plan.push_back(row(OP_TICK,  OFS_CTRLA,      8'h00, 0,  0,      218,  0, '0));
        plan.push_back(row(OP_READ,  OFS_RESL,       8'h00, 0,  0,      1,    0, '0));
        foreach (plan[i])
            repeat (plan[i].reps) send_item(plan[i].it, plan[i].typed, plan[i].want);

        drain_results();

        start_sent = n_sent;
        scen = 0;
        while (n_sent - start_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                gapless = !gapless;
            r = $urandom_range(0, 99);
            if (r < 65)
                run_conversion();
            else if (r < 85)
                repeat ($urandom_range(5, 20)) send_item(junk_item());
            else
                broken_sequence();
            scen++;
            if (scen % 40 == 7)
                drain_results();
        end
        in_valid <= 1'b0;

        for (int k = 0; k < 20000 && pending_results.size() != 0; k++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            n_fail += pending_results.size();
        end

        $display("Sent %0d transactions and checked %0d results, including %0d finished",
                 n_sent, n_checked, n_conversions);
        $display("conversions and %0d accesses to unmapped offsets.", n_unmapped);
        if (n_fail == 0)
            $display("adc_registers_with_timed_conversion_tb OK");
        else
            $display("adc_registers_with_timed_conversion_tb NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("%0t: timeout", $time);
        $display("adc_registers_with_timed_conversion_tb NOT OK");
        $finish;
    end

endmodule
